/* sv/mse_pkg.sv */
package mse_pkg;

  localparam int ActW = 4;
  localparam logic [ActW-1:0] ACT_RESET = 4'd8;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  stack_sel;
    logic [31:0] value;
  } mse_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [8:0]  count;
    logic        empty_res;
  } mse_res_t;

endpackage

/* sv/mse_cnt_mem.sv */
module mse_cnt_mem #(
  parameter int NUM  = 8,
  parameter int CntW = 9,
  parameter int IdxW = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [CntW-1:0] rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [CntW-1:0] wr_data_i
);

  logic [CntW-1:0] mem [NUM];
  logic [NUM-1:0]  vld_q;
  logic [CntW-1:0] rd_data_q;

  // entries not yet written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_idx_i] ? mem[rd_idx_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/mse_store.sv */
module mse_store #(
  parameter int Words = 2048,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [31:0]      wdata_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem [Words];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/multi_stack_engine.sv */
// done_o is registered from S_CNT for push, query, bad id, empty and full, after the count read;
// a pop or peek that returns a word goes on from S_CNT to S_DATA for the store read first.
// busy is high from the accept until the result is loaded, so no new command is taken while
// one is in flight; the next command can be taken in the cycle done_o is high.
// Reset: all stack counts read as zero, active_stacks is 8, store contents undefined.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
module multi_stack_engine #(
  parameter int MAX_STACKS  = 8,
  parameter int STACK_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mse_pkg::mse_req_t             req_i,
  input  logic                          cfg_we_i,
  input  logic [mse_pkg::ActW-1:0]      cfg_wdata_i,
  output logic                          done_o,
  output mse_pkg::mse_res_t             res_o
);

  import mse_pkg::*;

  localparam int SidW  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int Words = MAX_STACKS * STACK_DEPTH;
  localparam int AddrW = $clog2(Words);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CNT  = 3'b010,
    S_DATA = 3'b100
  } state_e;

  state_e          state_q, state_d;
  mse_req_t        req_q;
  logic [AddrW-1:0] base_q;
  logic            id_ok_q;
  logic [ActW-1:0] act_q;
  mse_res_t        res_q, res_d;
  logic            done_q, done_d;

  logic            acc;
  logic            id_ok;
  logic [AddrW-1:0] base_d;
  logic [CntW-1:0] cnt_rd;
  logic            cnt_we;
  logic [CntW-1:0] cnt_wdata;
  logic            st_we;
  logic            st_re;
  logic [AddrW-1:0] st_addr;
  logic [31:0]     st_rdata;

  assign busy   = (state_q != S_IDLE);
  assign acc    = start && !busy;
  assign id_ok  = (8'(req_i.stack_sel) < 8'(act_q)) && (8'(req_i.stack_sel) < 8'(MAX_STACKS));
  assign base_d = AddrW'(32'(SidW'(req_i.stack_sel)) * 32'(STACK_DEPTH));

  mse_cnt_mem #(
    .NUM  (MAX_STACKS),
    .CntW (CntW),
    .IdxW (SidW)
  ) u_cnt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_idx_i  (SidW'(req_i.stack_sel)),
    .rd_data_o (cnt_rd),
    .wr_en_i   (cnt_we),
    .wr_idx_i  (SidW'(req_q.stack_sel)),
    .wr_data_i (cnt_wdata)
  );

  mse_store #(
    .Words (Words),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .re_i    (st_re),
    .addr_i  (st_addr),
    .wdata_i (req_q.value),
    .rdata_o (st_rdata)
  );

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    done_d    = 1'b0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_rd;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_addr   = base_q + AddrW'(cnt_rd);
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = S_CNT;
        end
      end
      S_CNT: begin
        done_d          = 1'b1;
        state_d         = S_IDLE;
        res_d.status    = ST_OK;
        res_d.data      = '0;
        res_d.count     = 9'(cnt_rd);
        res_d.empty_res = (cnt_rd == '0);
        if (!id_ok_q) begin
          res_d.status    = ST_BAD_ID;
          res_d.count     = '0;
          res_d.empty_res = 1'b1;
        end else begin
          case (req_q.cmd)
            CMD_PUSH: begin
              if (cnt_rd == CntW'(STACK_DEPTH)) begin
                res_d.status = ST_FULL;
              end else begin
                st_we           = 1'b1;
                cnt_we          = 1'b1;
                cnt_wdata       = cnt_rd + CntW'(1);
                res_d.count     = 9'(cnt_wdata);
                res_d.empty_res = 1'b0;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (cnt_rd == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                st_re   = 1'b1;
                st_addr = base_q + AddrW'(cnt_rd) - AddrW'(1);
                done_d  = 1'b0;
                state_d = S_DATA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        done_d          = 1'b1;
        state_d         = S_IDLE;
        res_d.status    = ST_OK;
        res_d.data      = st_rdata;
        res_d.count     = 9'(cnt_rd);
        res_d.empty_res = (cnt_rd == '0);
        if (req_q.cmd == CMD_POP) begin
          cnt_we          = 1'b1;
          cnt_wdata       = cnt_rd - CntW'(1);
          res_d.count     = 9'(cnt_wdata);
          res_d.empty_res = (cnt_wdata == '0);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      act_q   <= ACT_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        act_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (acc) begin
      req_q   <= req_i;
      base_q  <= base_d;
      id_ok_q <= id_ok;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_CNT || state_q == S_DATA))
    else $error("result strobe without a command in flight");

  a_data_after_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DATA |-> $past(state_q == S_CNT))
    else $error("store read phase entered out of order");

  a_acc_to_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q == S_CNT)
    else $error("accepted command did not start count lookup");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status == ST_EMPTY || res_o.status == ST_BAD_ID)
      |-> res_o.empty_res && res_o.count == '0 && res_o.data == '0)
    else $error("error result carries nonzero count or data");

endmodule
